// File: hdl/nsb_pkg.sv
// ----------------------------------------------------------------------------
// nsb_pkg
// Shared widths, register map, reset values and the sine table generator
// for the noisy sine burst generator.
// ----------------------------------------------------------------------------
`default_nettype none

package nsb_pkg;

    // default build parameters
    localparam int MAX_POINTS_DEF     = 4096;
    localparam int SINE_ADDR_BITS_DEF = 12;

    // field widths
    localparam int NOISE_W  = 8;
    localparam int SAMPLE_W = 32;
    localparam int NPTS_W   = 13;
    localparam int PHASE_W  = 32;
    localparam int GAIN_W   = 16;
    localparam int BIAS_W   = 24;
    localparam int SINE_W   = 16;

    // apb port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_NUM_POINTS   = 3'd0,
        REG_PHASE_STEP   = 3'd1,
        REG_PHASE_OFFSET = 3'd2,
        REG_GAIN         = 3'd3,
        REG_NOISE_GAIN   = 3'd4,
        REG_BIAS         = 3'd5
    } t_reg_idx;

    // register reset values
    localparam logic [NPTS_W-1:0]  NUM_POINTS_RST   = 13'd64;
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 32'd67108864;
    localparam logic [PHASE_W-1:0] PHASE_OFFSET_RST = 32'd0;
    localparam logic [GAIN_W-1:0]  GAIN_RST         = 16'd256;
    localparam logic [GAIN_W-1:0]  NOISE_GAIN_RST   = 16'd0;
    localparam logic [BIAS_W-1:0]  BIAS_RST         = 24'd0;

    // reciprocal of 100 in Q0.29, exact for magnitudes below 2^22 + 1
    localparam int                 RECIP_SHIFT = 29;
    localparam logic [22:0]        NOISE_RECIP = 23'd5368710;

    // fixed point constants for the table series
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // one sine table entry: quadrant folding plus odd taylor series in q2.30,
    // rounded to q1.15 and clamped to +-32767; evaluated at elaboration only
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned addr,
                                                     input int unsigned abits);
        logic [63:0] quarter;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] mag;
        logic [1:0]  quad;
        logic [SINE_W-1:0] m16;
        quarter = 64'd1 << (abits - 2);
        quad    = 2'((64'(addr) >> (abits - 2)) & 64'd3);
        r       = 64'(addr) & (quarter - 64'd1);
        x       = quad[0] ? (quarter - r) : r;
        t       = (x * HALF_PI_Q30) >> (abits - 2);
        t2      = (t * t) >> 30;
        term    = ONE_Q30;
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd420);
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd342);
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd272);
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd210);
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd156);
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd110);
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd72);
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd42);
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd20);
        term    = ONE_Q30 - (((t2 * term) >> 30) / 64'd6);
        s       = (t * term) >> 30;
        mag     = (s + (64'd1 << 14)) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        m16 = mag[SINE_W-1:0];
        return quad[1] ? SINE_W'(-m16) : m16;
    endfunction

endpackage

`default_nettype wire

// File: hdl/nsb_if.sv
// ----------------------------------------------------------------------------
// nsb_if
// Valid/ready channels carrying noise input transactions and sample results.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsb_in_if;
    import nsb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [NOISE_W-1:0] noise_sample;
    logic                      restart;

    modport source (output valid, output noise_sample, output restart, input ready);
    modport sink   (input valid, input noise_sample, input restart, output ready);
endinterface

interface nsb_out_if;
    import nsb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_point;

    modport source (output valid, output sample_value, output last_point, input ready);
    modport sink   (input valid, input sample_value, input last_point, output ready);
endinterface

`default_nettype wire

// File: hdl/noisy_sine_burst_generator_core.sv
// ----------------------------------------------------------------------------
// noisy_sine_burst_generator_core: burst sine source with scaled noise and bias
// Stages from input transaction to result valid: rom read, two multiplier
// stages, sum. Throughput: one sample per clock while o_smp.ready holds;
// every stage moves independently so bubbles collapse under backpressure.
// Reset: synchronous, clears registers to defaults, index and phase to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module noisy_sine_burst_generator_core #(
    parameter int MAX_POINTS     = nsb_pkg::MAX_POINTS_DEF,
    parameter int SINE_ADDR_BITS = nsb_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nsb_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [nsb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [nsb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    // sample channels
    nsb_in_if.sink                                 i_smp,
    nsb_out_if.source                              o_smp
);
    import nsb_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int NL_W  = $clog2(MAX_POINTS + 1);
    localparam int CW    = (NL_W > NPTS_W) ? NL_W : NPTS_W;

    // configuration registers
    logic [NPTS_W-1:0]         r_num_points;
    logic [PHASE_W-1:0]        r_phase_step;
    logic [PHASE_W-1:0]        r_phase_offset;
    logic signed [GAIN_W-1:0]  r_gain;
    logic signed [GAIN_W-1:0]  r_noise_gain;
    logic signed [BIAS_W-1:0]  r_bias;
    logic                      w_cfg_wr;
    t_reg_idx                  w_reg_idx;

    // burst state
    logic [IDX_W-1:0]          r_index;
    logic [PHASE_W-1:0]        r_phase_acc;
    logic [IDX_W-1:0]          w_idx_eff;
    logic [PHASE_W-1:0]        w_acc_eff;
    logic [PHASE_W-1:0]        w_phase;
    logic [CW-1:0]             w_np_ext;
    logic [CW-1:0]             w_n_lim;
    logic                      w_last;
    logic                      w_in_acc;

    // stage enables
    logic                      w_en1;
    logic                      w_en2;
    logic                      w_en3;
    logic                      w_en4;

    // stage valids and payload
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      r_v4;
    logic signed [NOISE_W-1:0] r_s1_noise;
    logic                      r_s1_last;
    logic signed [SINE_W-1:0]  w_rom_q;
    logic signed [31:0]        w_sine_prod;
    logic signed [23:0]        w_noise_prod;
    logic signed [31:0]        r_s2_sine_prod;
    logic signed [23:0]        r_s2_noise_prod;
    logic                      r_s2_last;
    logic [23:0]               w_noise_neg24;
    logic [22:0]               w_noise_mag;
    logic [45:0]               w_q_prod;
    logic signed [16:0]        r_s3_sine_term;
    logic [16:0]               r_s3_noise_q;
    logic                      r_s3_noise_neg;
    logic                      r_s3_last;
    logic signed [17:0]        w_noise_term;
    logic signed [SAMPLE_W-1:0] w_sum;
    logic signed [SAMPLE_W-1:0] r_s4_value;
    logic                      r_s4_last;

    // apb register file
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= NUM_POINTS_RST;
            r_phase_step   <= PHASE_STEP_RST;
            r_phase_offset <= PHASE_OFFSET_RST;
            r_gain         <= GAIN_RST;
            r_noise_gain   <= NOISE_GAIN_RST;
            r_bias         <= BIAS_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_NUM_POINTS:   r_num_points   <= pwdata[NPTS_W-1:0];
                REG_PHASE_STEP:   r_phase_step   <= pwdata[PHASE_W-1:0];
                REG_PHASE_OFFSET: r_phase_offset <= pwdata[PHASE_W-1:0];
                REG_GAIN:         r_gain         <= $signed(pwdata[GAIN_W-1:0]);
                REG_NOISE_GAIN:   r_noise_gain   <= $signed(pwdata[GAIN_W-1:0]);
                REG_BIAS:         r_bias         <= $signed(pwdata[BIAS_W-1:0]);
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            REG_NUM_POINTS:   prdata = APB_DATA_W'(r_num_points);
            REG_PHASE_STEP:   prdata = r_phase_step;
            REG_PHASE_OFFSET: prdata = r_phase_offset;
            REG_GAIN:         prdata = APB_DATA_W'($unsigned(r_gain));
            REG_NOISE_GAIN:   prdata = APB_DATA_W'($unsigned(r_noise_gain));
            REG_BIAS:         prdata = APB_DATA_W'($unsigned(r_bias));
            default:          prdata = '0;
        endcase
    end

    // stage enables, each stage moves when it is empty or the next one is moving
    assign w_en4       = !r_v4 || o_smp.ready;
    assign w_en3       = !r_v3 || w_en4;
    assign w_en2       = !r_v2 || w_en3;
    assign w_en1       = !r_v1 || w_en2;
    assign i_smp.ready = w_en1;
    assign w_in_acc    = i_smp.valid && w_en1;

    // burst length limit: zero acts as one, clamp to the largest burst
    assign w_np_ext = CW'(r_num_points);
    assign w_n_lim  = (w_np_ext == '0) ? CW'(1) :
                      (w_np_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : w_np_ext;

    // restart clears the state ahead of this sample
    assign w_idx_eff = i_smp.restart ? '0 : r_index;
    assign w_acc_eff = i_smp.restart ? '0 : r_phase_acc;
    assign w_phase   = r_phase_offset + w_acc_eff;
    assign w_last    = CW'(w_idx_eff) >= (w_n_lim - CW'(1));

    // index and phase advance, wrap after the final point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_phase_acc <= '0;
        end else if (w_in_acc) begin
            if (w_last) begin
                r_index     <= '0;
                r_phase_acc <= '0;
            end else begin
                r_index     <= w_idx_eff + IDX_W'(1);
                r_phase_acc <= w_acc_eff + r_phase_step;
            end
        end
    end

    // sine table lookup on the top phase bits
    nsb_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_en1),
        .i_addr (w_phase[PHASE_W-1 -: SINE_ADDR_BITS]),
        .o_data (w_rom_q)
    );

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_smp.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // stage 1: noise and flag alongside the rom read
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_noise <= i_smp.noise_sample;
            r_s1_last  <= w_last;
        end
    end

    // stage 2: gain and noise products
    assign w_sine_prod  = 32'(r_gain) * 32'(w_rom_q);
    assign w_noise_prod = 24'(r_s1_noise) * 24'(r_noise_gain);

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_sine_prod  <= w_sine_prod;
            r_s2_noise_prod <= w_noise_prod;
            r_s2_last       <= r_s1_last;
        end
    end

    // stage 3: floor shift of the sine term, noise magnitude times 1/100
    assign w_noise_neg24 = 24'(-r_s2_noise_prod);
    assign w_noise_mag   = r_s2_noise_prod[23] ? w_noise_neg24[22:0]
                                               : r_s2_noise_prod[22:0];
    assign w_q_prod      = 46'(w_noise_mag) * 46'(NOISE_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_sine_term <= 17'(r_s2_sine_prod >>> 15);
            r_s3_noise_q   <= w_q_prod[RECIP_SHIFT +: 17];
            r_s3_noise_neg <= r_s2_noise_prod[23];
            r_s3_last      <= r_s2_last;
        end
    end

    // stage 4: signed noise term and final sum; the operands cannot leave
    // the 32-bit range, so the sum never needs clamping
    assign w_noise_term = r_s3_noise_neg ? -$signed({1'b0, r_s3_noise_q})
                                         :  $signed({1'b0, r_s3_noise_q});
    assign w_sum = SAMPLE_W'(r_s3_sine_term) + SAMPLE_W'(w_noise_term)
                 + SAMPLE_W'(r_bias);

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_s4_value <= w_sum;
            r_s4_last  <= r_s3_last;
        end
    end

    // result channel
    assign o_smp.valid        = r_v4;
    assign o_smp.sample_value = r_s4_value;
    assign o_smp.last_point   = r_s4_last;

`ifndef SYNTHESIS
    // final point of a burst returns index and phase to zero
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last) |=> (r_index == '0 && r_phase_acc == '0))
        else $error("burst state did not wrap after last point");

    // any other sample advances the phase by one step
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_last) |=> (r_phase_acc == $past(w_acc_eff + r_phase_step)))
        else $error("phase accumulator did not advance by one step");

    // input is refused only when every stage holds a sample
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.ready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input stalled with a free pipeline stage");
`endif

endmodule

`default_nettype wire

// File: hdl/nsb_sine_rom.sv
// ----------------------------------------------------------------------------
// nsb_sine_rom
// Full-wave q1.15 sine table with a registered read port and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module nsb_sine_rom #(
    parameter int SINE_ADDR_BITS = nsb_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [SINE_ADDR_BITS-1:0]         i_addr,
    output logic signed [nsb_pkg::SINE_W-1:0]      o_data
);
    import nsb_pkg::*;

    localparam int DEPTH = 1 << SINE_ADDR_BITS;

    logic [SINE_W-1:0]        w_rom [DEPTH];
    logic signed [SINE_W-1:0] r_data;

    // table contents fixed at elaboration
    for (genvar a = 0; a < DEPTH; a++) begin : g_rom
        localparam logic [SINE_W-1:0] ENTRY = sine_entry(a, SINE_ADDR_BITS);
        assign w_rom[a] = ENTRY;
    end

    // registered read, holds while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= $signed(w_rom[i_addr]);
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
